/* hw/rtl/playfair_encryptor_unit_defines.svh */
// assertion macros shared by the playfair encryptor rtl
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef PLAYFAIR_ENCRYPTOR_UNIT_DEFINES_SVH
`define PLAYFAIR_ENCRYPTOR_UNIT_DEFINES_SVH

// same-cycle implication
`define PFE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PFE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/pfe_pkg.sv */
// shared types, constants and square arithmetic for the playfair encryptor
// no dependencies
package pfe_pkg;

	localparam int LETTERS    = 26;
	localparam int CELLS      = 25;
	localparam int SIDE       = 5;
	localparam int LETTER_W   = 5;
	localparam int CELL_W     = 5;
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [LETTER_W-1:0] LETTER_I    = LETTER_W'(8);
	localparam logic [LETTER_W-1:0] LETTER_J    = LETTER_W'(9);
	localparam logic [LETTER_W-1:0] LETTER_X    = LETTER_W'(23);
	localparam logic [LETTER_W-1:0] LETTER_LAST = LETTER_W'(LETTERS - 1);

	localparam logic [1:0] FUNC_KEY    = 2'd0;
	localparam logic [1:0] FUNC_FINISH = 2'd1;
	localparam logic [1:0] FUNC_TEXT   = 2'd2;
	localparam logic [1:0] FUNC_END    = 2'd3;

	typedef enum logic [1:0] {
		OP_KEY,
		OP_FINISH,
		OP_PAIR
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic                restart;
		logic [LETTER_W-1:0] a;
		logic [LETTER_W-1:0] b;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic [LETTER_W-1:0] fold_j(input logic [LETTER_W-1:0] l);
		return (l == LETTER_J) ? LETTER_I : l;
	endfunction

	function automatic logic [CELL_W-1:0] cell_at(input logic [2:0] row, input logic [2:0] col);
		return CELL_W'(row) * CELL_W'(SIDE) + CELL_W'(col);
	endfunction

	function automatic logic [2:0] cell_row(input logic [CELL_W-1:0] p);
		logic [2:0] r;
		if (p >= CELL_W'(4 * SIDE)) r = 3'd4;
		else if (p >= CELL_W'(3 * SIDE)) r = 3'd3;
		else if (p >= CELL_W'(2 * SIDE)) r = 3'd2;
		else if (p >= CELL_W'(SIDE)) r = 3'd1;
		else r = 3'd0;
		return r;
	endfunction

	function automatic logic [2:0] cell_col(input logic [CELL_W-1:0] p);
		logic [CELL_W-1:0] d;
		d = p - cell_at(cell_row(p), 3'd0);
		return d[2:0];
	endfunction

	function automatic logic [2:0] step_wrap(input logic [2:0] x);
		return (x == 3'(SIDE - 1)) ? 3'd0 : x + 3'd1;
	endfunction

endpackage

/* hw/rtl/pfe_ram.sv */
// generic ram, one write port and two registered read ports
// no dependencies
module pfe_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 26,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_a_q;
	logic [WIDTH-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a_q <= mem_q[raddr_a];
		rdata_b_q <= mem_q[raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

/* hw/rtl/pfe_front.sv */
// front end: accepts requests, tracks square completion and open pair
// depends on pfe_pkg
module pfe_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [1:0]                   func,
	input  logic [pfe_pkg::LETTER_W-1:0] letter,
	input  pfe_pkg::fifo_stat_t          stat,
	output logic                         push,
	output pfe_pkg::cmd_t                cmd
);

	logic                         complete_q;
	logic                         pend_valid_q;
	logic [pfe_pkg::LETTER_W-1:0] pend_q;
	logic                         accept;
	logic                         in_range;
	logic                         need_push;

	assign req_stall = stat.full;
	assign accept    = req_valid && !stat.full;
	assign in_range  = letter <= pfe_pkg::LETTER_LAST;
	assign push      = accept && need_push;

	always_comb begin
		need_push   = 1'b0;
		cmd.op      = pfe_pkg::OP_KEY;
		cmd.restart = complete_q;
		cmd.a       = pfe_pkg::fold_j(letter);
		cmd.b       = pfe_pkg::LETTER_X;
		case (func)
			pfe_pkg::FUNC_KEY: begin
				need_push = in_range;
			end
			pfe_pkg::FUNC_FINISH: begin
				need_push = !complete_q;
				cmd.op    = pfe_pkg::OP_FINISH;
			end
			pfe_pkg::FUNC_TEXT: begin
				need_push = complete_q && in_range && pend_valid_q;
				cmd.op    = pfe_pkg::OP_PAIR;
				cmd.a     = pfe_pkg::fold_j(pend_q);
				cmd.b     = (pend_q == letter) ? pfe_pkg::LETTER_X : pfe_pkg::fold_j(letter);
			end
			pfe_pkg::FUNC_END: begin
				need_push = complete_q && pend_valid_q;
				cmd.op    = pfe_pkg::OP_PAIR;
				cmd.a     = pfe_pkg::fold_j(pend_q);
			end
			default: begin
				need_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			complete_q   <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (accept) begin
			case (func)
				pfe_pkg::FUNC_KEY: begin
					if (in_range && complete_q) begin
						complete_q   <= 1'b0;
						pend_valid_q <= 1'b0;
					end
				end
				pfe_pkg::FUNC_FINISH: begin
					complete_q <= 1'b1;
				end
				pfe_pkg::FUNC_TEXT: begin
					if (complete_q && in_range) begin
						if (!pend_valid_q) begin
							pend_valid_q <= 1'b1;
						end else if (pend_q != letter) begin
							pend_valid_q <= 1'b0;
						end
					end
				end
				pfe_pkg::FUNC_END: begin
					if (complete_q) begin
						pend_valid_q <= 1'b0;
					end
				end
				default: begin
					complete_q <= complete_q;
				end
			endcase
		end
	end

	// open letter payload
	always_ff @(posedge clk) begin
		if (accept && func == pfe_pkg::FUNC_TEXT && complete_q && in_range && !pend_valid_q) begin
			pend_q <= letter;
		end
	end

endmodule

/* hw/rtl/pfe_fifo.sv */
// short command queue between front and back
// depends on pfe_pkg
module pfe_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pfe_pkg::cmd_t       wdata,
	input  logic                pop,
	output pfe_pkg::cmd_t       rdata,
	output pfe_pkg::fifo_stat_t stat
);

	pfe_pkg::cmd_t                  mem_q [pfe_pkg::FIFO_DEPTH];
	logic [pfe_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [pfe_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [pfe_pkg::FIFO_CNT_W-1:0] count_q;

	function automatic logic [pfe_pkg::FIFO_PTR_W-1:0] next_ptr(
		input logic [pfe_pkg::FIFO_PTR_W-1:0] p
	);
		return (p == pfe_pkg::FIFO_PTR_W'(pfe_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign rdata      = mem_q[rd_ptr_q];
	assign stat.full  = count_q == pfe_pkg::FIFO_CNT_W'(pfe_pkg::FIFO_DEPTH);
	assign stat.empty = count_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

/* hw/rtl/pfe_back.sv */
// back end: key schedule, square memories, digraph encryption, result register
// depends on pfe_pkg, pfe_ram and playfair_encryptor_unit_defines.svh
`include "playfair_encryptor_unit_defines.svh"

module pfe_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pfe_pkg::cmd_t                head,
	input  pfe_pkg::fifo_stat_t          stat,
	output logic                         pop,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [pfe_pkg::LETTER_W-1:0] cipher_letter,
	output logic                         last_of_pair
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_LOOKUP,
		ST_OUT1,
		ST_OUT2
	} state_t;

	state_t                       state_q;
	logic [pfe_pkg::LETTERS-1:0]  used_q;
	logic [pfe_pkg::CELL_W-1:0]   cursor_q;
	logic [pfe_pkg::LETTER_W-1:0] sweep_q;
	logic [pfe_pkg::CELL_W-1:0]   ea_q;
	logic [pfe_pkg::CELL_W-1:0]   eb_q;
	logic                         rsp_valid_q;
	logic [pfe_pkg::LETTER_W-1:0] cipher_q;
	logic                         last_q;

	logic                         out_free;
	logic                         is_key;
	logic                         restart;
	logic [pfe_pkg::LETTER_W-1:0] place_letter;
	logic                         used_bit;
	logic                         room;
	logic                         wr_en;
	logic [pfe_pkg::CELL_W-1:0]   wr_cell;
	logic [pfe_pkg::CELL_W-1:0]   pa;
	logic [pfe_pkg::CELL_W-1:0]   pb;
	logic [pfe_pkg::CELL_W-1:0]   ea;
	logic [pfe_pkg::CELL_W-1:0]   eb;
	logic [pfe_pkg::CELL_W-1:0]   sq_raddr_a;
	logic [pfe_pkg::CELL_W-1:0]   sq_raddr_b;
	logic [pfe_pkg::LETTER_W-1:0] sq_rd_a;
	logic [pfe_pkg::LETTER_W-1:0] sq_rd_b;
	logic [2:0]                   ra;
	logic [2:0]                   ca;
	logic [2:0]                   rb;
	logic [2:0]                   cb;

	assign pop      = (state_q == ST_IDLE) && !stat.empty;
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign is_key   = pop && head.op == pfe_pkg::OP_KEY;
	assign restart  = is_key && head.restart;

	// key placement and finish sweep share one write path
	assign place_letter = (state_q == ST_FILL) ? sweep_q : head.a;
	assign used_bit     = used_q[place_letter];
	assign room         = cursor_q < pfe_pkg::CELL_W'(pfe_pkg::CELLS);
	assign wr_cell      = restart ? '0 : cursor_q;

	always_comb begin
		wr_en = 1'b0;
		if (is_key) begin
			wr_en = restart || (!used_bit && room);
		end else if (state_q == ST_FILL) begin
			wr_en = (sweep_q != pfe_pkg::LETTER_J) && !used_bit && room;
		end
	end

	pfe_ram #(
		.WIDTH (pfe_pkg::CELL_W),
		.DEPTH (pfe_pkg::LETTERS)
	) u_pos_ram (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (place_letter),
		.wdata   (wr_cell),
		.raddr_a (head.a),
		.raddr_b (head.b),
		.rdata_a (pa),
		.rdata_b (pb)
	);

	// row, column or rectangle rule
	always_comb begin
		ra = pfe_pkg::cell_row(pa);
		ca = pfe_pkg::cell_col(pa);
		rb = pfe_pkg::cell_row(pb);
		cb = pfe_pkg::cell_col(pb);
		if (ra == rb) begin
			ea = pfe_pkg::cell_at(ra, pfe_pkg::step_wrap(ca));
			eb = pfe_pkg::cell_at(rb, pfe_pkg::step_wrap(cb));
		end else if (ca == cb) begin
			ea = pfe_pkg::cell_at(pfe_pkg::step_wrap(ra), ca);
			eb = pfe_pkg::cell_at(pfe_pkg::step_wrap(rb), cb);
		end else begin
			ea = pfe_pkg::cell_at(ra, cb);
			eb = pfe_pkg::cell_at(rb, ca);
		end
	end

	assign sq_raddr_a = (state_q == ST_LOOKUP) ? ea : ea_q;
	assign sq_raddr_b = (state_q == ST_LOOKUP) ? eb : eb_q;

	pfe_ram #(
		.WIDTH (pfe_pkg::LETTER_W),
		.DEPTH (pfe_pkg::CELLS)
	) u_square_ram (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (wr_cell),
		.wdata   (place_letter),
		.raddr_a (sq_raddr_a),
		.raddr_b (sq_raddr_b),
		.rdata_a (sq_rd_a),
		.rdata_b (sq_rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			cursor_q    <= '0;
			sweep_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						case (head.op)
							pfe_pkg::OP_KEY: begin
								if (restart) begin
									used_q   <= '0;
									cursor_q <= '0;
								end
							end
							pfe_pkg::OP_FINISH: begin
								sweep_q <= '0;
								state_q <= ST_FILL;
							end
							pfe_pkg::OP_PAIR: begin
								state_q <= ST_LOOKUP;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_FILL: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == pfe_pkg::LETTER_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_LOOKUP: begin
					state_q <= ST_OUT1;
				end
				ST_OUT1: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_OUT2;
					end
				end
				ST_OUT2: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (wr_en) begin
				used_q[place_letter] <= 1'b1;
				cursor_q             <= wr_cell + 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_LOOKUP) begin
			ea_q <= ea;
			eb_q <= eb;
		end
		if (state_q == ST_OUT1 && out_free) begin
			cipher_q <= sq_rd_a;
			last_q   <= 1'b0;
		end
		if (state_q == ST_OUT2 && out_free) begin
			cipher_q <= sq_rd_b;
			last_q   <= 1'b1;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign cipher_letter = cipher_q;
	assign last_of_pair  = last_q;

	`PFE_ASSERT_IMP(a_cursor_counts_used, 1'b1, cursor_q == pfe_pkg::CELL_W'($countones(used_q)), "fill cursor out of step with used letters")
	`PFE_ASSERT_NXT(a_finish_fills_square, state_q == ST_FILL && sweep_q == pfe_pkg::LETTER_LAST, cursor_q == pfe_pkg::CELL_W'(pfe_pkg::CELLS), "square not full after finish")
	`PFE_ASSERT_IMP(a_first_then_second, rsp_valid_q && !last_q, state_q == ST_OUT2, "first cipher letter without second pending")
	`PFE_ASSERT_IMP(a_no_j_out, rsp_valid_q, cipher_q != pfe_pkg::LETTER_J, "cipher letter J produced")

endmodule

/* hw/rtl/playfair_encryptor_unit.sv */
// playfair encryptor top level: front end, command queue, back end
// depends on pfe_pkg, pfe_front, pfe_fifo, pfe_back
//
// request channel (req_valid / req_stall) carries func and letter: key letters,
// finish, plaintext letters and end of message. result channel (rsp_valid /
// rsp_stall) carries cipher_letter and last_of_pair, two results per digraph.
// a key letter is placed as it leaves the queue. a finish sweeps the alphabet
// once, writing the unused letters other than J into the square.
// a digraph passes through queue, position lookup, square lookup and result
// register after the request that closes it. the back end takes no new command
// until the second letter of a digraph is in the result register, since the two
// memory reads depend on each other and a single result register serves both.
// plaintext before the square is complete is dropped with no result.
// reset empties the queue, clears the square state and any open pair; the
// square memories keep no reset and are rewritten by the next key.
// a stalled result holds; the back end waits and the two-entry queue
// absorbs requests until full, then req_stall rises.
module playfair_encryptor_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [1:0]                   func,
	input  logic [pfe_pkg::LETTER_W-1:0] letter,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [pfe_pkg::LETTER_W-1:0] cipher_letter,
	output logic                         last_of_pair
);

	pfe_pkg::fifo_stat_t stat;
	pfe_pkg::cmd_t       push_cmd;
	pfe_pkg::cmd_t       head;
	logic                push;
	logic                pop;

	pfe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.func      (func),
		.letter    (letter),
		.stat      (stat),
		.push      (push),
		.cmd       (push_cmd)
	);

	pfe_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_cmd),
		.pop    (pop),
		.rdata  (head),
		.stat   (stat)
	);

	pfe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.stat          (stat),
		.pop           (pop),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.cipher_letter (cipher_letter),
		.last_of_pair  (last_of_pair)
	);

endmodule
